FILE: rtl/slxfc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package slxfc_pkg;

    localparam logic [7:0] SYNC_BYTES    = 8'd4;
    localparam logic [7:0] HEADER_BYTES  = 8'd6;
    localparam logic [7:0] LEN_LO_POS    = 8'd4;
    localparam logic [7:0] LEN_HI_POS    = 8'd5;
    localparam logic [7:0] LEN_EXTRA     = 8'd2;
    localparam logic [7:0] MIN_CAP       = 8'd2;

    localparam int unsigned HDR_DEPTH    = 5;
    localparam int unsigned HDR_IDX_W    = $clog2(HDR_DEPTH);

    localparam int unsigned CFG_IDX_W    = 3;
    localparam int unsigned CFG_DATA_W   = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_FIRST   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_SECOND  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_VERSION_HIGH = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_VERSION_LOW  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LENGTH   = 3'd4;

    localparam logic [7:0] RST_SYNC_FIRST   = 8'd170;
    localparam logic [7:0] RST_SYNC_SECOND  = 8'd51;
    localparam logic [7:0] RST_VERSION_HIGH = 8'd0;
    localparam logic [7:0] RST_VERSION_LOW  = 8'd2;
    localparam logic [7:0] RST_MAX_LENGTH   = 8'd138;

    typedef struct packed {
        logic        frame_ok;
        logic [7:0]  frame_length;
        logic [15:0] received_check;
        logic [7:0]  computed_xor;
    } result_t;

endpackage

`default_nettype wire

FILE: rtl/slxfc_in_stage.sv
`timescale 1ns / 1ps
`default_nettype none

module slxfc_in_stage
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [7:0] rx_byte,
    input  wire logic       advance_ok,
    output logic            stage_valid,
    output logic [7:0]      stage_byte
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;

    // a held request can only sit while the result side is blocked
    assign in_stall   = valid_reg && !advance_ok;
    assign valid_next = in_stall ? valid_reg : in_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall)
        begin
            byte_reg <= rx_byte;
        end
    end

    assign stage_valid = valid_reg;
    assign stage_byte  = byte_reg;

endmodule

`default_nettype wire

FILE: rtl/slxfc_core.sv
`timescale 1ns / 1ps
`default_nettype none

module slxfc_core
    import slxfc_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  fire,
    input  wire logic [7:0]            rx_byte,
    output logic                       res_valid,
    output result_t                    res
);

    logic [7:0] sync_first_reg;
    logic [7:0] sync_second_reg;
    logic [7:0] version_high_reg;
    logic [7:0] version_low_reg;
    logic [7:0] max_length_reg;

    logic [7:0] cnt_reg;
    logic [7:0] cnt_next;
    logic [7:0] target_reg;
    logic [7:0] target_next;
    logic [7:0] hdr_reg [HDR_DEPTH];
    logic [7:0] xor_reg;
    logic [7:0] xor_prev_reg;
    logic [7:0] prev_reg;

    logic [7:0]           cnt_inc;
    logic                 hunting;
    logic [7:0]           want;
    logic                 take;
    logic                 base_zero;
    logic [7:0]           base;
    logic                 hdr_we;
    logic [HDR_IDX_W-1:0] hdr_idx;
    logic                 emit_short;
    logic                 emit_long;

    logic [16:0] len_sum;
    logic [7:0]  cap;
    logic [7:0]  len;
    logic        len_short;
    logic [15:0] short_check;
    logic [7:0]  short_xor;
    logic [15:0] long_check;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_first_reg   <= RST_SYNC_FIRST;
            sync_second_reg  <= RST_SYNC_SECOND;
            version_high_reg <= RST_VERSION_HIGH;
            version_low_reg  <= RST_VERSION_LOW;
            max_length_reg   <= RST_MAX_LENGTH;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_SYNC_FIRST:   sync_first_reg   <= cfg_data;
                CFG_SYNC_SECOND:  sync_second_reg  <= cfg_data;
                CFG_VERSION_HIGH: version_high_reg <= cfg_data;
                CFG_VERSION_LOW:  version_low_reg  <= cfg_data;
                CFG_MAX_LENGTH:   max_length_reg   <= cfg_data;
                default:          ;
            endcase
        end
    end

    assign cnt_inc = cnt_reg + 8'd1;
    assign hunting = cnt_reg < SYNC_BYTES;

    always_comb
    begin
        unique case (cnt_reg[1:0])
            2'd0:    want = sync_first_reg;
            2'd1:    want = sync_second_reg;
            2'd2:    want = version_high_reg;
            default: want = version_low_reg;
        endcase
    end

    // length field plus two, capped
    assign len_sum   = {1'b0, rx_byte, hdr_reg[LEN_LO_POS[HDR_IDX_W-1:0]]} + 17'(LEN_EXTRA);
    assign cap       = (max_length_reg < MIN_CAP) ? MIN_CAP : max_length_reg;
    assign len       = (len_sum > {9'd0, cap}) ? cap : len_sum[7:0];
    assign len_short = len <= HEADER_BYTES;

    // frame made of header bytes only, judged on the last length byte
    always_comb
    begin
        unique case (len[2:0])
            3'd3:
            begin
                short_check = {hdr_reg[2], hdr_reg[1]};
                short_xor   = hdr_reg[0];
            end
            3'd4:
            begin
                short_check = {hdr_reg[3], hdr_reg[2]};
                short_xor   = hdr_reg[0] ^ hdr_reg[1];
            end
            3'd5:
            begin
                short_check = {hdr_reg[4], hdr_reg[3]};
                short_xor   = hdr_reg[0] ^ hdr_reg[1] ^ hdr_reg[2];
            end
            3'd6:
            begin
                short_check = {rx_byte, hdr_reg[4]};
                short_xor   = hdr_reg[0] ^ hdr_reg[1] ^ hdr_reg[2] ^ hdr_reg[3];
            end
            default:
            begin
                short_check = {hdr_reg[1], hdr_reg[0]};
                short_xor   = 8'd0;
            end
        endcase
    end

    assign long_check = {rx_byte, prev_reg};

    always_comb
    begin
        cnt_next    = cnt_reg;
        target_next = target_reg;
        take        = 1'b0;
        base_zero   = 1'b0;
        hdr_we      = 1'b0;
        hdr_idx     = cnt_reg[HDR_IDX_W-1:0];
        emit_short  = 1'b0;
        emit_long   = 1'b0;
        if (fire)
        begin
            priority if (hunting)
            begin
                if (rx_byte == want)
                begin
                    take      = 1'b1;
                    base_zero = cnt_reg == 8'd0;
                    hdr_we    = 1'b1;
                    cnt_next  = cnt_inc;
                end
                else if (rx_byte == sync_first_reg)
                begin
                    // retest as the first sync byte
                    take      = 1'b1;
                    base_zero = 1'b1;
                    hdr_we    = 1'b1;
                    hdr_idx   = '0;
                    cnt_next  = 8'd1;
                end
                else
                begin
                    cnt_next = 8'd0;
                end
            end
            else if (cnt_reg == LEN_LO_POS)
            begin
                take     = 1'b1;
                hdr_we   = 1'b1;
                cnt_next = cnt_inc;
            end
            else if (cnt_reg == LEN_HI_POS)
            begin
                take = 1'b1;
                if (len_short)
                begin
                    emit_short = 1'b1;
                    cnt_next   = 8'd0;
                end
                else
                begin
                    target_next = len;
                    cnt_next    = cnt_inc;
                end
            end
            else
            begin
                take = 1'b1;
                if (cnt_inc >= target_reg)
                begin
                    emit_long = 1'b1;
                    cnt_next  = 8'd0;
                end
                else
                begin
                    cnt_next = cnt_inc;
                end
            end
        end
    end

    assign base = base_zero ? 8'd0 : xor_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg    <= 8'd0;
            target_reg <= 8'd0;
        end
        else
        begin
            cnt_reg    <= cnt_next;
            target_reg <= target_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (hdr_we)
        begin
            hdr_reg[hdr_idx] <= rx_byte;
        end
        if (take)
        begin
            xor_prev_reg <= base;
            xor_reg      <= base ^ rx_byte;
            prev_reg     <= rx_byte;
        end
    end

    assign res_valid = emit_short || emit_long;

    always_comb
    begin
        if (emit_short)
        begin
            res.frame_length   = len;
            res.received_check = short_check;
            res.computed_xor   = short_xor;
        end
        else
        begin
            res.frame_length   = target_reg;
            res.received_check = long_check;
            res.computed_xor   = xor_prev_reg;
        end
        res.frame_ok = res.received_check == {8'd0, res.computed_xor};
    end

endmodule

`default_nettype wire

FILE: rtl/slxfc_out_stage.sv
`timescale 1ns / 1ps
`default_nettype none

module slxfc_out_stage
    import slxfc_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     res_valid,
    input  wire result_t  res,
    output logic          out_free,
    output logic          out_valid,
    input  wire logic     out_stall,
    output result_t       out_res
);

    logic    valid_reg;
    result_t res_reg;

    assign out_free = !valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free && res_valid)
        begin
            res_reg <= res;
        end
    end

    assign out_valid = valid_reg;
    assign out_res   = res_reg;

endmodule

`default_nettype wire

FILE: rtl/sync_length_xor_frame_checker.sv
// a request passes the input register, then the result register if it gives a result
// throughput: one byte per cycle; only a stalled result blocks the input register
// a frame result appears with its completing byte, a byte that completes nothing gives none
// reset: rst_n is asynchronous, active low; it returns the hunt to the first sync byte,
// drops any held request and result, and loads the register defaults
`timescale 1ns / 1ps
`default_nettype none

module sync_length_xor_frame_checker
    import slxfc_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic [7:0]            rx_byte,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic                       frame_ok,
    output logic [7:0]                 frame_length,
    output logic [15:0]                received_check,
    output logic [7:0]                 computed_xor,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    logic       out_free;
    logic       stage_valid;
    logic [7:0] stage_byte;
    logic       fire;
    logic       res_valid;
    result_t    res;
    result_t    out_res;

    slxfc_in_stage u_in
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .rx_byte     (rx_byte),
        .advance_ok  (out_free),
        .stage_valid (stage_valid),
        .stage_byte  (stage_byte)
    );

    assign fire = stage_valid && out_free;

    slxfc_core u_core
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .fire      (fire),
        .rx_byte   (stage_byte),
        .res_valid (res_valid),
        .res       (res)
    );

    slxfc_out_stage u_out
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res       (res),
        .out_free  (out_free),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_res   (out_res)
    );

    assign frame_ok       = out_res.frame_ok;
    assign frame_length   = out_res.frame_length;
    assign received_check = out_res.received_check;
    assign computed_xor   = out_res.computed_xor;

endmodule

`default_nettype wire

FILE: rtl/slxfc_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module slxfc_checker
    import slxfc_pkg::*;
(
    input wire logic                  clk,
    input wire logic                  rst_n,
    input wire logic                  in_stall,
    input wire logic                  out_valid,
    input wire logic                  out_stall,
    input wire logic                  frame_ok,
    input wire logic [7:0]            frame_length,
    input wire logic [15:0]           received_check,
    input wire logic [7:0]            computed_xor
);

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(frame_length)
            && $stable(received_check) && $stable(computed_xor) && $stable(frame_ok))
        else $error("stalled result changed");

    // verdict agrees with the reported words
    a_verdict: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> frame_ok == (received_check == {8'd0, computed_xor}))
        else $error("frame_ok disagrees with check and xor");

    // frame length is never below the two check bytes
    a_min_len: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> frame_length >= MIN_CAP)
        else $error("frame length below minimum");

    // input only backs up behind a stalled result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without output backpressure");

    // no stall the cycle after reset release
    a_reset_idle: assert property (@(posedge clk)
        !rst_n |=> !out_valid && !in_stall)
        else $error("handshake active out of reset");

endmodule

bind sync_length_xor_frame_checker slxfc_checker u_slxfc_checker (.*);

`default_nettype wire

FILE: tb/sync_length_xor_frame_checker_tb.sv
`timescale 1ns / 1ps

module sync_length_xor_frame_checker_tb;

    import slxfc_pkg::*;

    localparam int unsigned WATCHDOG_LIMIT = 4000;
    localparam int unsigned HOLD_CYCLES    = 300;
    localparam int unsigned SETTLE_CYCLES  = 8;
    localparam int unsigned IDLE_PCT       = 7;

    logic                  clk;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic [7:0]            rx_byte = 8'h00;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic                  frame_ok;
    logic [7:0]            frame_length;
    logic [15:0]           received_check;
    logic [7:0]            computed_xor;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_SYNC_FIRST;
    logic [CFG_DATA_W-1:0] cfg_data = 8'h00;

    // register shadows
    logic [7:0] sync_a  = RST_SYNC_FIRST;
    logic [7:0] sync_b  = RST_SYNC_SECOND;
    logic [7:0] ver_hi  = RST_VERSION_HIGH;
    logic [7:0] ver_lo  = RST_VERSION_LOW;
    logic [7:0] len_cap = RST_MAX_LENGTH;

    // deframer state
    logic [7:0] pos = 8'h00;
    logic [7:0] frame_len = 8'h00;
    logic [7:0] hdr [HEADER_BYTES];
    logic [7:0] acc_xor = 8'h00;
    logic [7:0] xor_prev [2];
    logic [7:0] tail [2];

    logic [7:0]  pending_bytes [$];
    result_t     awaited_frames [$];
    result_t     want_frame;
    int unsigned bytes_queued = 0;
    int unsigned bytes_accepted = 0;
    int unsigned frame_items = 0;
    int unsigned mismatch_count = 0;
    int unsigned quiet_cycles = 0;
    int unsigned hold_left = 0;
    int unsigned frames_taken = 0;
    bit          calm = 1'b0;

    sync_length_xor_frame_checker uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .rx_byte        (rx_byte),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .frame_ok       (frame_ok),
        .frame_length   (frame_length),
        .received_check (received_check),
        .computed_xor   (computed_xor),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    task automatic clear_frame();
        pos       = 8'h00;
        frame_len = 8'h00;
        foreach (hdr[i])
        begin
            hdr[i] = 8'h00;
        end
        acc_xor     = 8'h00;
        xor_prev[0] = 8'h00;
        xor_prev[1] = 8'h00;
        tail[0]     = 8'h00;
        tail[1]     = 8'h00;
    endtask

    task automatic take_byte(input logic [7:0] b);
        if (pos < HEADER_BYTES)
        begin
            hdr[pos] = b;
        end
        xor_prev[0] = xor_prev[1];
        xor_prev[1] = acc_xor;
        acc_xor     = acc_xor ^ b;
        tail[0]     = tail[1];
        tail[1]     = b;
        pos         = pos + 8'd1;
    endtask

    task automatic record_frame(input int unsigned span, input logic [15:0] chk,
                                input logic [7:0] x);
        result_t r;
        r.frame_ok       = (chk == {8'h00, x});
        r.frame_length   = span[7:0];
        r.received_check = chk;
        r.computed_xor   = x;
        awaited_frames = {awaited_frames, r};
        clear_frame();
    endtask

    task automatic follow_byte(input logic [7:0] b);
        logic [7:0]  want;
        int unsigned span;
        int unsigned lim;
        logic [7:0]  x;
        if (pos < SYNC_BYTES)
        begin
            case (pos)
                8'd0:    want = sync_a;
                8'd1:    want = sync_b;
                8'd2:    want = ver_hi;
                default: want = ver_lo;
            endcase
            if (b == want)
            begin
                take_byte(b);
            end
            else
            begin
                clear_frame();
                if (b == sync_a)
                begin
                    take_byte(b);
                end
            end
        end
        else
        begin
            take_byte(b);
            if (pos == HEADER_BYTES)
            begin
                span = 32'({hdr[LEN_HI_POS], hdr[LEN_LO_POS]}) + 32'(LEN_EXTRA);
                lim  = (len_cap < MIN_CAP) ? 32'(MIN_CAP) : 32'(len_cap);
                if (span > lim)
                begin
                    span = lim;
                end
                frame_len = span[7:0];
                if (span <= 32'(HEADER_BYTES))
                begin
                    x = 8'h00;
                    for (int i = 0; i + 32'(LEN_EXTRA) < span; i++)
                    begin
                        x = x ^ hdr[i];
                    end
                    record_frame(span, {hdr[span - 1], hdr[span - 2]}, x);
                end
            end
            else if (pos > HEADER_BYTES && pos >= frame_len)
            begin
                record_frame(32'(frame_len), {tail[1], tail[0]}, xor_prev[0]);
            end
        end
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (mismatch_count < 40)
        begin
            $display("mismatch on %s: got %0h, want %0h at %0t", what, got, want, $time);
        end
        mismatch_count++;
    endtask

    // request driver
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                follow_byte(rx_byte);
                bytes_accepted++;
            end
            if (!in_valid || !in_stall)
            begin
                if (pending_bytes.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT))
                begin
                    in_valid <= 1'b1;
                    rx_byte  <= pending_bytes.pop_front();
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // result receiver, with long hold-offs to back up the pipeline
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                frames_taken++;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (out_valid && !out_stall && (frames_taken == 4 || frames_taken == 40))
            begin
                hold_left = HOLD_CYCLES;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
            end
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (awaited_frames.size() == 0)
            begin
                report_mismatch("unexpected frame", 32'(received_check), 32'h0);
            end
            else
            begin
                want_frame = awaited_frames.pop_front();
                if (frame_ok !== want_frame.frame_ok)
                begin
                    report_mismatch("frame_ok", 32'(frame_ok), 32'(want_frame.frame_ok));
                end
                if (frame_length !== want_frame.frame_length)
                begin
                    report_mismatch("frame_length", 32'(frame_length),
                                    32'(want_frame.frame_length));
                end
                if (received_check !== want_frame.received_check)
                begin
                    report_mismatch("received_check", 32'(received_check),
                                    32'(want_frame.received_check));
                end
                if (computed_xor !== want_frame.computed_xor)
                begin
                    report_mismatch("computed_xor", 32'(computed_xor),
                                    32'(want_frame.computed_xor));
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_SYNC_FIRST:   sync_a  = val;
            CFG_SYNC_SECOND:  sync_b  = val;
            CFG_VERSION_HIGH: ver_hi  = val;
            CFG_VERSION_LOW:  ver_lo  = val;
            CFG_MAX_LENGTH:   len_cap = val;
            default:          ;
        endcase
    endtask

    task automatic add_byte(input logic [7:0] b);
        pending_bytes = {pending_bytes, b};
        bytes_queued++;
    endtask

    task automatic queue_frame(input logic [15:0] len_field, input bit good);
        logic [7:0]  fb [$];
        int unsigned span;
        int unsigned lim;
        logic [7:0]  x;
        fb   = {sync_a, sync_b, ver_hi, ver_lo, len_field[7:0], len_field[15:8]};
        lim  = (len_cap < MIN_CAP) ? 32'(MIN_CAP) : 32'(len_cap);
        span = 32'(len_field) + 32'(LEN_EXTRA);
        if (span > lim)
        begin
            span = lim;
        end
        while (fb.size() + 32'(LEN_EXTRA) < span)
        begin
            fb = {fb, 8'($urandom)};
        end
        if (span == 32'(HEADER_BYTES) + 1)
        begin
            fb = {fb, (good ? 8'h00 : 8'($urandom))};
        end
        else if (span > 32'(HEADER_BYTES) + 1)
        begin
            x = 8'h00;
            foreach (fb[i])
            begin
                x = x ^ fb[i];
            end
            fb = {fb, (good ? x : 8'($urandom))};
            fb = {fb, (good ? 8'h00 : 8'($urandom))};
        end
        foreach (fb[i])
        begin
            add_byte(fb[i]);
        end
        frame_items += fb.size();
    endtask

    function automatic logic [15:0] random_len();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 55)
        begin
            return 16'($urandom_range(12));
        end
        else if (r < 85)
        begin
            return 16'($urandom_range(40));
        end
        else if (r < 95)
        begin
            return 16'($urandom_range(253));
        end
        return 16'($urandom_range(16'hFFFF, 16'h00FE));
    endfunction

    task automatic run_random(input int unsigned n);
        int unsigned stop;
        int unsigned r;
        int unsigned k;
        stop = frame_items + n;
        while (frame_items < stop)
        begin
            r = $urandom_range(99);
            if (r < 80)
            begin
                queue_frame(random_len(), $urandom_range(99) < 60);
            end
            else if (r < 90)
            begin
                k = $urandom_range(4, 1);
                repeat (k)
                begin
                    add_byte(($urandom_range(3) == 0) ? sync_a : 8'($urandom));
                end
            end
            else
            begin
                // header cut short, then a stray byte
                k = $urandom_range(3, 1);
                add_byte(sync_a);
                if (k > 1)
                begin
                    add_byte(sync_b);
                end
                if (k > 2)
                begin
                    add_byte(ver_hi);
                end
                add_byte(($urandom_range(1) == 0) ? sync_a : 8'($urandom));
            end
        end
    endtask

    task automatic drain();
        do
        begin
            @(posedge clk);
        end
        while (bytes_accepted != bytes_queued || awaited_frames.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        clear_frame();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // defaults: short frame, retest of sync, good 8 byte frame, broken header
        queue_frame(16'd0, 1'b0);
        add_byte(sync_a);
        queue_frame(16'd4, 1'b0);
        queue_frame(16'd6, 1'b1);
        add_byte(sync_a);
        add_byte(sync_b);
        add_byte(~ver_hi);
        run_random(300);
        drain();

        write_reg(CFG_SYNC_FIRST, 8'($urandom));
        write_reg(CFG_SYNC_SECOND, 8'($urandom));
        write_reg(CFG_VERSION_HIGH, 8'($urandom));
        write_reg(CFG_VERSION_LOW, 8'($urandom));
        write_reg(CFG_MAX_LENGTH, 8'hFF);
        run_random(300);
        drain();

        write_reg(CFG_SYNC_FIRST, 8'h00);
        write_reg(CFG_SYNC_SECOND, 8'hFF);
        write_reg(CFG_VERSION_HIGH, 8'hFF);
        write_reg(CFG_VERSION_LOW, 8'h00);
        write_reg(CFG_MAX_LENGTH, 8'd6);
        calm = 1'b1;
        run_random(250);
        drain();
        calm = 1'b0;

        // equal sync bytes of zero make a length-0 frame pass
        write_reg(CFG_SYNC_SECOND, 8'h00);
        write_reg(CFG_VERSION_HIGH, 8'($urandom));
        write_reg(CFG_VERSION_LOW, 8'($urandom));
        write_reg(CFG_MAX_LENGTH, 8'($urandom_range(40, 7)));
        run_random(250);
        drain();

        write_reg(CFG_SYNC_FIRST, RST_SYNC_FIRST);
        write_reg(CFG_SYNC_SECOND, RST_SYNC_SECOND);
        write_reg(CFG_VERSION_HIGH, RST_VERSION_HIGH);
        write_reg(CFG_VERSION_LOW, RST_VERSION_LOW);
        write_reg(CFG_MAX_LENGTH, RST_MAX_LENGTH);
        run_random(300);
        drain();

        if (mismatch_count == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

FILE: sim.f
rtl/slxfc_pkg.sv
rtl/slxfc_in_stage.sv
rtl/slxfc_core.sv
rtl/slxfc_out_stage.sv
rtl/sync_length_xor_frame_checker.sv
rtl/slxfc_checker.sv
tb/sync_length_xor_frame_checker_tb.sv
